// ===== hw/rtl/tsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_pkg - shared types and constants for the Taylor sine/cosine block
// Fixed widths of the datapath, internal guard bits and the sequencer states.
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam int CFG_W      = 5;
    localparam int ANGLE_W    = 32;
    localparam int OUT_W      = 48;
    localparam int GUARD      = 14;

    localparam int TERM_W     = 62;
    localparam int TERM_HI_W  = TERM_W - ANGLE_W;
    localparam int MUL_W      = 2 * ANGLE_W;
    localparam int PROD_W     = TERM_W + ANGLE_W;
    localparam int EXT_W      = 128;
    localparam int Q_W        = 64;
    localparam int SUM_W      = 63;
    localparam int ACC_W      = 64;

    localparam int DIV_STEP   = 4;
    localparam int DIV_CYC    = Q_W / DIV_STEP;
    localparam int DCNT_W     = $clog2(DIV_CYC);

    localparam logic [CFG_W-1:0]  TERM_COUNT_RST = 5'd8;
    localparam logic [TERM_W-1:0] TERM_CAP       = {1'b1, {(TERM_W-1){1'b0}}};
    localparam logic [TERM_W-1:0] ROUND_HALF     = TERM_W'(1) << (GUARD - 1);
    localparam logic [OUT_W-1:0]  OUT_MAX        = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0]  OUT_MIN_MAG    = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC,
        ST_CHK,
        ST_DIV,
        ST_QCHK,
        ST_ABS,
        ST_RND,
        ST_DONE
    } t_state;

endpackage

// ===== hw/rtl/taylor_sine_cosine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taylor_sine_cosine - truncated Taylor series for sine or cosine
// Sums term_count series terms of sin(x) or cos(x) in fixed point, Q4.28 in,
// Q20.28 out with saturation flag.
// ----------------------------------------------------------------------------
// One transaction at a time. The input is stalled from acceptance until the
// result is loaded into the output register; a finished result may wait there
// while the next transaction is accepted. The block sums n = min(term_count,
// MAX_TERMS) terms; each term after the first needs two multiply-divide steps,
// and each step is two passes through one shared 32x32 multiplier, an
// accumulate, and a 64-bit divide by the small series index that retires 4
// quotient bits per cycle. A step that overflows skips its divide.
// ----------------------------------------------------------------------------
module taylor_sine_cosine #(
    parameter int MAX_TERMS = 16,
    parameter int FRAC_BITS = 28
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tsc_pkg::CFG_W-1:0]           i_cfg_data,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_func,
    input  logic signed [tsc_pkg::ANGLE_W-1:0]  i_angle,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [tsc_pkg::OUT_W-1:0]    o_approx,
    output logic                                o_saturated
);

    localparam int IW = $clog2(MAX_TERMS + 1);
    localparam int KW = (MAX_TERMS > 1) ? $clog2(2 * MAX_TERMS) : 1;

    tsc_pkg::t_state r_state, n_state;

    logic [tsc_pkg::CFG_W-1:0]     r_term_count, n_term_count;
    logic                          r_cos, n_cos;
    logic                          r_xneg, n_xneg;
    logic [tsc_pkg::ANGLE_W-1:0]   r_x, n_x;
    logic [IW-1:0]                 r_n, n_n;
    logic [IW-1:0]                 r_i, n_i;
    logic [KW-1:0]                 r_k, n_k;
    logic                          r_second, n_second;
    logic [tsc_pkg::TERM_W-1:0]    r_t, n_t;
    logic signed [tsc_pkg::SUM_W-1:0] r_sum, n_sum;
    logic                          r_sat, n_sat;
    logic [tsc_pkg::MUL_W-1:0]     r_mp, n_mp;
    logic [tsc_pkg::PROD_W-1:0]    r_prod, n_prod;
    logic [tsc_pkg::Q_W-1:0]       r_dvd, n_dvd;
    logic [KW-1:0]                 r_rem, n_rem;
    logic [tsc_pkg::DCNT_W-1:0]    r_dcnt, n_dcnt;
    logic [tsc_pkg::OUT_W-1:0]     r_rnd, n_rnd;
    logic                          r_out_valid, n_out_valid;
    logic signed [tsc_pkg::OUT_W-1:0] r_approx, n_approx;
    logic                          r_saturated, n_saturated;

    // shared multiplier
    logic [tsc_pkg::ANGLE_W-1:0]   mul_a;
    logic [tsc_pkg::MUL_W-1:0]     mul_p;

    assign mul_a = (r_state == tsc_pkg::ST_MUL_HI)
                 ? tsc_pkg::ANGLE_W'(r_t[tsc_pkg::TERM_W-1:tsc_pkg::ANGLE_W])
                 : r_t[tsc_pkg::ANGLE_W-1:0];
    assign mul_p = tsc_pkg::MUL_W'(mul_a) * tsc_pkg::MUL_W'(r_x);

    // product scaling and overflow check
    logic [tsc_pkg::EXT_W-1:0]     prod_ext;
    logic                          prod_ovf;
    logic [tsc_pkg::Q_W-1:0]       prod_q;

    assign prod_ext = tsc_pkg::EXT_W'(r_prod);
    assign prod_ovf = |(prod_ext >> (tsc_pkg::Q_W + FRAC_BITS));
    assign prod_q   = prod_ext[FRAC_BITS +: tsc_pkg::Q_W];

    // divider: DIV_STEP restoring steps per cycle
    logic [tsc_pkg::Q_W-1:0]       div_dvd;
    logic [KW-1:0]                 div_rem;

    always_comb begin
        logic [KW:0] tmp;
        div_dvd = r_dvd;
        div_rem = r_rem;
        for (int j = 0; j < tsc_pkg::DIV_STEP; j++) begin
            tmp     = {div_rem, div_dvd[tsc_pkg::Q_W-1]};
            div_dvd = {div_dvd[tsc_pkg::Q_W-2:0], 1'b0};
            if (tmp >= {1'b0, r_k}) begin
                div_rem    = KW'(tmp - {1'b0, r_k});
                div_dvd[0] = 1'b1;
            end else begin
                div_rem = tmp[KW-1:0];
            end
        end
    end

    // term accumulation with clip
    logic                          term_neg;
    logic signed [tsc_pkg::ACC_W-1:0] acc_s, acc_t, acc_r, acc_cap;

    assign term_neg = r_i[0] ^ (!r_cos && r_xneg);
    assign acc_s    = tsc_pkg::ACC_W'(r_sum);
    assign acc_t    = $signed({2'b00, r_t});
    assign acc_cap  = $signed({2'b00, tsc_pkg::TERM_CAP});
    assign acc_r    = term_neg ? (acc_s - acc_t) : (acc_s + acc_t);

    // next term index and first divisor
    logic [IW-1:0]                 i_next;
    logic [KW-1:0]                 k_first;

    assign i_next  = r_i + IW'(1);
    assign k_first = KW'({i_next, 1'b0}) - KW'(r_cos);

    logic                          sum_neg;
    assign sum_neg = r_sum[tsc_pkg::SUM_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tsc_pkg::ST_IDLE;
            r_term_count <= tsc_pkg::TERM_COUNT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_term_count <= n_term_count;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cos       <= n_cos;
        r_xneg      <= n_xneg;
        r_x         <= n_x;
        r_n         <= n_n;
        r_i         <= n_i;
        r_k         <= n_k;
        r_second    <= n_second;
        r_t         <= n_t;
        r_sum       <= n_sum;
        r_sat       <= n_sat;
        r_mp        <= n_mp;
        r_prod      <= n_prod;
        r_dvd       <= n_dvd;
        r_rem       <= n_rem;
        r_dcnt      <= n_dcnt;
        r_rnd       <= n_rnd;
        r_approx    <= n_approx;
        r_saturated <= n_saturated;
    end

    always_comb begin
        logic       step_done;
        logic [tsc_pkg::TERM_W-1:0] step_t;
        logic       step_sat;
        logic [IW-1:0] cnt;

        n_state      = r_state;
        n_term_count = r_term_count;
        n_cos        = r_cos;
        n_xneg       = r_xneg;
        n_x          = r_x;
        n_n          = r_n;
        n_i          = r_i;
        n_k          = r_k;
        n_second     = r_second;
        n_t          = r_t;
        n_sum        = r_sum;
        n_sat        = r_sat;
        n_mp         = r_mp;
        n_prod       = r_prod;
        n_dvd        = r_dvd;
        n_rem        = r_rem;
        n_dcnt       = r_dcnt;
        n_rnd        = r_rnd;
        n_approx     = r_approx;
        n_saturated  = r_saturated;
        n_out_valid  = r_out_valid & i_out_stall;
        step_done    = 1'b0;
        step_t       = r_t;
        step_sat     = 1'b0;
        cnt          = (r_term_count > MAX_TERMS) ? IW'(MAX_TERMS) : IW'(r_term_count);

        if (i_cfg_valid && o_cfg_ready) begin
            n_term_count = i_cfg_data;
        end

        case (r_state)
            tsc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_cos  = i_func;
                    n_xneg = i_angle[tsc_pkg::ANGLE_W-1];
                    n_x    = i_angle[tsc_pkg::ANGLE_W-1]
                           ? (tsc_pkg::ANGLE_W'(0) - i_angle) : i_angle;
                    n_n    = cnt;
                    n_i    = '0;
                    n_sum  = '0;
                    n_sat  = 1'b0;
                    n_t    = i_func ? (tsc_pkg::TERM_W'(1) << (FRAC_BITS + tsc_pkg::GUARD))
                                    : (tsc_pkg::TERM_W'(n_x) << tsc_pkg::GUARD);
                    n_state = (cnt == '0) ? tsc_pkg::ST_ABS : tsc_pkg::ST_ADD;
                end
            end
            tsc_pkg::ST_ADD: begin
                if (acc_r > acc_cap) begin
                    n_sum = tsc_pkg::SUM_W'(acc_cap);
                    n_sat = 1'b1;
                end else if (acc_r < -acc_cap) begin
                    n_sum = tsc_pkg::SUM_W'(-acc_cap);
                    n_sat = 1'b1;
                end else begin
                    n_sum = tsc_pkg::SUM_W'(acc_r);
                end
                n_i = i_next;
                if (i_next == r_n) begin
                    n_state = tsc_pkg::ST_ABS;
                end else begin
                    n_k      = k_first;
                    n_second = 1'b0;
                    n_state  = tsc_pkg::ST_MUL_LO;
                end
            end
            tsc_pkg::ST_MUL_LO: begin
                n_mp    = mul_p;
                n_state = tsc_pkg::ST_MUL_HI;
            end
            tsc_pkg::ST_MUL_HI: begin
                n_prod  = tsc_pkg::PROD_W'(r_mp);
                n_mp    = mul_p;
                n_state = tsc_pkg::ST_ACC;
            end
            tsc_pkg::ST_ACC: begin
                n_prod  = r_prod + (tsc_pkg::PROD_W'(r_mp) << tsc_pkg::ANGLE_W);
                n_state = tsc_pkg::ST_CHK;
            end
            tsc_pkg::ST_CHK: begin
                if (prod_ovf) begin
                    step_done = 1'b1;
                    step_t    = tsc_pkg::TERM_CAP;
                    step_sat  = 1'b1;
                end else begin
                    n_dvd   = prod_q;
                    n_rem   = '0;
                    n_dcnt  = '0;
                    n_state = tsc_pkg::ST_DIV;
                end
            end
            tsc_pkg::ST_DIV: begin
                n_dvd  = div_dvd;
                n_rem  = div_rem;
                n_dcnt = r_dcnt + tsc_pkg::DCNT_W'(1);
                if (r_dcnt == tsc_pkg::DCNT_W'(tsc_pkg::DIV_CYC - 1)) begin
                    n_state = tsc_pkg::ST_QCHK;
                end
            end
            tsc_pkg::ST_QCHK: begin
                step_done = 1'b1;
                if (r_dvd > tsc_pkg::Q_W'(tsc_pkg::TERM_CAP)) begin
                    step_t   = tsc_pkg::TERM_CAP;
                    step_sat = 1'b1;
                end else begin
                    step_t = r_dvd[tsc_pkg::TERM_W-1:0];
                end
            end
            tsc_pkg::ST_ABS: begin
                n_t     = sum_neg ? tsc_pkg::TERM_W'(-r_sum) : tsc_pkg::TERM_W'(r_sum);
                n_state = tsc_pkg::ST_RND;
            end
            tsc_pkg::ST_RND: begin
                n_rnd   = tsc_pkg::OUT_W'((r_t + tsc_pkg::ROUND_HALF) >> tsc_pkg::GUARD);
                n_state = tsc_pkg::ST_DONE;
            end
            tsc_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_saturated = r_sat;
                    if (!sum_neg && r_rnd > tsc_pkg::OUT_MAX) begin
                        n_approx    = $signed(tsc_pkg::OUT_MAX);
                        n_saturated = 1'b1;
                    end else if (sum_neg && r_rnd > tsc_pkg::OUT_MIN_MAG) begin
                        n_approx    = $signed(tsc_pkg::OUT_MIN_MAG);
                        n_saturated = 1'b1;
                    end else begin
                        n_approx = sum_neg ? $signed(tsc_pkg::OUT_W'(0) - r_rnd)
                                           : $signed(r_rnd);
                    end
                    n_state = tsc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tsc_pkg::ST_IDLE;
            end
        endcase

        if (step_done) begin
            n_t   = step_t;
            n_sat = r_sat | step_sat;
            if (!r_second) begin
                n_second = 1'b1;
                n_k      = r_k + KW'(1);
                n_state  = tsc_pkg::ST_MUL_LO;
            end else begin
                n_state = tsc_pkg::ST_ADD;
            end
        end
    end

    assign o_cfg_ready = (r_state == tsc_pkg::ST_IDLE);
    assign o_in_stall  = (r_state != tsc_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_approx    = r_approx;
    assign o_saturated = r_saturated;

`ifndef ASSERT_OFF
    a_div_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tsc_pkg::ST_DIV) |-> (r_rem < r_k))
        else $error("divider remainder not below divisor");

    a_term_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != tsc_pkg::ST_IDLE) |-> (r_t <= tsc_pkg::TERM_CAP))
        else $error("term magnitude above cap");

    a_sum_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != tsc_pkg::ST_IDLE) |->
        ((tsc_pkg::ACC_W'(r_sum) <= acc_cap) && (tsc_pkg::ACC_W'(r_sum) >= -acc_cap)))
        else $error("partial sum outside clip range");

    a_term_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tsc_pkg::ST_ADD) |-> (r_i < r_n))
        else $error("term index past term count");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == tsc_pkg::ST_DONE) && (!r_out_valid || !i_out_stall)) |=>
        (o_out_valid && (r_state == tsc_pkg::ST_IDLE)))
        else $error("result not loaded into output register");
`endif

endmodule

// ===== tb/tb_taylor_sine_cosine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_taylor_sine_cosine - self-checking bench for the Taylor sine/cosine block
// Drives angle/function transactions with random gaps and output stalls over
// several term counts. Each result is checked against an in-bench fixed-point
// series evaluator, in order and field by field.
// ----------------------------------------------------------------------------
module tb_taylor_sine_cosine;

    localparam int MAX_TERMS  = 16;
    localparam int FRAC       = 28;
    localparam int CYCLE_CAP  = 8_000_000;
    localparam int NUM_PHASES = 10;

    localparam logic [63:0]        TERM_LIMIT = 64'(tsc_pkg::TERM_CAP);
    localparam logic signed [63:0] SUM_LIMIT  = 64'(tsc_pkg::TERM_CAP);
    localparam logic [63:0]        OUT_LIMIT  = 64'(tsc_pkg::OUT_MAX);

    localparam logic [31:0] ANGLE_ONE     = 32'h1000_0000;
    localparam logic [31:0] ANGLE_HALF_PI = 32'd421657428;
    localparam logic [31:0] ANGLE_PI      = 32'd843314857;

    typedef struct packed {
        logic        func;
        logic [31:0] angle;
    } t_item;

    typedef struct packed {
        logic [47:0] approx;
        logic        saturated;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [tsc_pkg::CFG_W-1:0] i_cfg_data = '0;
    logic o_cfg_ready;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_func = 1'b0;
    logic signed [tsc_pkg::ANGLE_W-1:0] i_angle = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [tsc_pkg::OUT_W-1:0] o_approx;
    logic o_saturated;

    t_item   pending_items[$];
    t_result expected_results[$];
    logic [tsc_pkg::CFG_W-1:0] term_setting = tsc_pkg::TERM_COUNT_RST;

    int mismatch_count = 0;
    int cycle_count = 0;
    int send_gap = 0;
    int send_calm = 0;
    int recv_gap = 0;
    int recv_calm = 0;
    logic send_busy;
    t_item next_item;
    t_result want;

    int phase_terms [NUM_PHASES] = '{0, 1, 2, 3, 16, 31, 17, 5, 8, 12};
    int phase_items [NUM_PHASES] = '{100, 200, 300, 300, 60, 40, 20, 300, 300, 180};

    taylor_sine_cosine #(
        .MAX_TERMS(MAX_TERMS),
        .FRAC_BITS(FRAC)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_func(i_func),
        .i_angle(i_angle),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_approx(o_approx),
        .o_saturated(o_saturated)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // T := floor(floor(T*|x| / 2^FRAC) / k), clipped to the term cap
    function automatic logic [63:0] scale_term(input logic [63:0] t, input logic [32:0] mag,
                                               input int unsigned k, inout logic sat);
        logic [127:0] prod;
        logic [63:0] q;
        prod = {64'd0, t} * {95'd0, mag};
        if ((prod >> (64 + FRAC)) != 0) begin
            sat = 1'b1;
            return TERM_LIMIT;
        end
        q = 64'(prod >> FRAC);
        q = q / 64'(k);
        if (q > TERM_LIMIT) begin
            sat = 1'b1;
            return TERM_LIMIT;
        end
        return q;
    endfunction

    function automatic t_result series_eval(input logic func, input logic [31:0] angle,
                                            input logic [tsc_pkg::CFG_W-1:0] terms);
        logic xneg;
        logic [32:0] mag;
        int unsigned n;
        int unsigned k;
        logic [63:0] t;
        logic signed [63:0] sum;
        logic [63:0] m;
        logic [63:0] r;
        logic sneg;
        logic tneg;
        logic sat;
        t_result res;
        xneg = angle[31];
        mag = xneg ? (33'h1_0000_0000 - {1'b0, angle}) : {1'b0, angle};
        n = (terms > MAX_TERMS) ? MAX_TERMS : terms;
        sum = '0;
        sat = 1'b0;
        t = func ? (64'd1 << (FRAC + tsc_pkg::GUARD)) : (64'(mag) << tsc_pkg::GUARD);
        for (int unsigned i = 0; i < n; i++) begin
            if (i > 0) begin
                k = func ? (2 * i - 1) : (2 * i);
                t = scale_term(t, mag, k, sat);
                t = scale_term(t, mag, k + 1, sat);
            end
            tneg = (i[0] == 1'b1) != (!func && xneg);
            sum = tneg ? sum - $signed(t) : sum + $signed(t);
            if (sum > SUM_LIMIT) begin
                sum = SUM_LIMIT;
                sat = 1'b1;
            end else if (sum < -SUM_LIMIT) begin
                sum = -SUM_LIMIT;
                sat = 1'b1;
            end
        end
        sneg = sum < 0;
        m = sneg ? 64'(-sum) : 64'(sum);
        r = (m + (64'd1 << (tsc_pkg::GUARD - 1))) >> tsc_pkg::GUARD;
        if (!sneg && r > OUT_LIMIT) begin
            r = OUT_LIMIT;
            sat = 1'b1;
        end else if (sneg && r > OUT_LIMIT + 1) begin
            r = OUT_LIMIT + 1;
            sat = 1'b1;
        end
        res.approx = sneg ? 48'(64'd0 - r) : r[47:0];
        res.saturated = sat;
        return res;
    endfunction

    // per-transaction idle count, with occasional runs of back-to-back traffic
    function automatic int draw_idle(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [31:0] draw_angle();
        logic [31:0] a;
        case ($urandom_range(0, 9)) inside
            [0:4]: a = $urandom_range(0, ANGLE_PI);
            5: a = $urandom_range(0, ANGLE_ONE);
            6: begin
                case ($urandom_range(0, 3))
                    0: a = 32'h8000_0000 + $urandom_range(0, 15);
                    1: a = 32'h7FFF_FFFF - $urandom_range(0, 15);
                    default: a = $urandom_range(0, 15);
                endcase
            end
            default: a = $urandom;
        endcase
        if ($urandom_range(0, 1) == 1 && a[31] == 1'b0)
            a = 32'd0 - a;
        return a;
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            send_busy = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(series_eval(i_func, i_angle, term_setting));
                send_busy = 1'b0;
                send_gap = draw_idle(send_calm);
            end
            if (!send_busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_items.size() > 0) begin
                    next_item = pending_items.pop_front();
                    i_func <= next_item.func;
                    i_angle <= next_item.angle;
                    send_busy = 1'b1;
                end
            end
            i_in_valid <= send_busy;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            recv_gap = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected transaction: approx=%0d saturated=%0b",
                                 o_approx, o_saturated);
                end else begin
                    want = expected_results.pop_front();
                    if (o_approx !== want.approx || o_saturated !== want.saturated) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp approx=%0d sat=%0b, got approx=%0d sat=%0b",
                                     $signed(want.approx), want.saturated, o_approx, o_saturated);
                    end
                end
                recv_gap = draw_idle(recv_calm);
            end else if (o_out_valid && recv_gap > 0) begin
                recv_gap--;
            end
            i_out_stall <= (recv_gap > 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // sampled mid-cycle so the driver's updates of the same edge are settled
    task automatic drain();
        while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_terms(input logic [tsc_pkg::CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        term_setting = value;
    endtask

    initial begin
        t_item it;
        logic [31:0] edge_angles [10];
        edge_angles = '{32'd0, 32'd1, 32'hFFFF_FFFF, ANGLE_ONE, 32'd0 - ANGLE_ONE,
                        ANGLE_HALF_PI, 32'd0 - ANGLE_HALF_PI, ANGLE_PI,
                        32'h7FFF_FFFF, 32'h8000_0000};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners at the reset term count
        for (int f = 0; f < 2; f++) begin
            foreach (edge_angles[j]) begin
                it.func = f[0];
                it.angle = edge_angles[j];
                pending_items.push_back(it);
            end
        end
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_terms(phase_terms[p][tsc_pkg::CFG_W-1:0]);
            for (int j = 0; j < phase_items[p]; j++) begin
                it.func = 1'($urandom_range(0, 1));
                it.angle = draw_angle();
                pending_items.push_back(it);
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
